FILE: src/triangle_midpoint_subdivider_core_macros.svh
// Assertion macros for the subdivider core.
// Both expect clk and arst_n in the scope of use.
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDER_CORE_MACROS_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TMS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tms assertion failed");

// next-cycle implication
`define TMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tms assertion failed");

`else

`define TMS_ASSERT_IMPL(label, ante, cons)
`define TMS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/tms_pkg.sv
package tms_pkg;

	// deepest split supported
	localparam int MAX_DEPTH = 3;

	localparam int COORD_W  = 16;
	localparam int LEVELS_W = 2;

	// one stack row per level
	localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vtx_t;

	typedef struct packed {
		vtx_t a;
		vtx_t b;
		vtx_t c;
	} tri_t;

	// child order of one split
	typedef enum logic [1:0] {
		CH_A   = 2'd0,
		CH_B   = 2'd1,
		CH_C   = 2'd2,
		CH_MID = 2'd3
	} child_t;

endpackage

FILE: src/tms_stack_ram.sv
// Triangle stack: one row per level, registered read.
module tms_stack_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [tms_pkg::ADDR_W-1:0] waddr,
	input  tms_pkg::tri_t              wdata,
	input  logic                       re,
	input  logic [tms_pkg::ADDR_W-1:0] raddr,
	output tms_pkg::tri_t              rdata
);

	tms_pkg::tri_t mem [tms_pkg::MAX_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/tms_split.sv
// Edge midpoints of a parent triangle and selection of one child.
module tms_split (
	input  tms_pkg::tri_t   parent,
	input  tms_pkg::child_t sel,
	output tms_pkg::tri_t   child
);

	tms_pkg::vtx_t m0;
	tms_pkg::vtx_t m1;
	tms_pkg::vtx_t m2;

	// wrapped 16-bit sum, halved toward zero
	function automatic logic signed [tms_pkg::COORD_W-1:0] half_sum(
		input logic signed [tms_pkg::COORD_W-1:0] u,
		input logic signed [tms_pkg::COORD_W-1:0] v
	);
		logic signed [tms_pkg::COORD_W-1:0] s;
		logic signed [tms_pkg::COORD_W-1:0] adj;
		s   = u + v;
		adj = s + {{(tms_pkg::COORD_W-1){1'b0}}, s[tms_pkg::COORD_W-1]};
		return adj >>> 1;
	endfunction

	function automatic tms_pkg::vtx_t mid(
		input tms_pkg::vtx_t u,
		input tms_pkg::vtx_t v
	);
		tms_pkg::vtx_t m;
		m.x = half_sum(u.x, v.x);
		m.y = half_sum(u.y, v.y);
		m.z = half_sum(u.z, v.z);
		return m;
	endfunction

	// midpoints of BC, CA, AB
	assign m0 = mid(parent.b, parent.c);
	assign m1 = mid(parent.c, parent.a);
	assign m2 = mid(parent.a, parent.b);

	// child select
	always_comb begin
		case (sel)
			tms_pkg::CH_A: begin
				child = '{a: parent.a, b: m2, c: m1};
			end
			tms_pkg::CH_B: begin
				child = '{a: parent.b, b: m0, c: m2};
			end
			tms_pkg::CH_C: begin
				child = '{a: parent.c, b: m1, c: m0};
			end
			default: begin
				child = '{a: m0, b: m1, c: m2};
			end
		endcase
	end

endmodule

FILE: src/triangle_midpoint_subdivider_core.sv
// channel | valid     | stall     | payload
// --------+-----------+-----------+-----------------------------------------
// input   | in_valid  | in_stall  | a_x..c_z, levels
// output  | out_valid | out_stall | p_x..r_z, final_triangle
//
// Depth d (levels 0 taken as 1, clamped to MAX_DEPTH) gives 4^d transactions.
// A group of four leaves leaves at one per cycle from the parent register, unless
// out_stall holds the emit state; the next group under the same parent passes
// the states next, read, load and descend, plus one more next and descend
// when the walk climbs a level.
// Input is taken only when the sequencer is idle; the last result may still
// be waiting in the output register. Output stall freezes the sequencer
// in the emit state. Reset clears control only; the stack needs no clearing.
`include "triangle_midpoint_subdivider_core_macros.svh"

module triangle_midpoint_subdivider_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [tms_pkg::COORD_W-1:0]   a_x,
	input  logic signed [tms_pkg::COORD_W-1:0]   a_y,
	input  logic signed [tms_pkg::COORD_W-1:0]   a_z,
	input  logic signed [tms_pkg::COORD_W-1:0]   b_x,
	input  logic signed [tms_pkg::COORD_W-1:0]   b_y,
	input  logic signed [tms_pkg::COORD_W-1:0]   b_z,
	input  logic signed [tms_pkg::COORD_W-1:0]   c_x,
	input  logic signed [tms_pkg::COORD_W-1:0]   c_y,
	input  logic signed [tms_pkg::COORD_W-1:0]   c_z,
	input  logic        [tms_pkg::LEVELS_W-1:0]  levels,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [tms_pkg::COORD_W-1:0]   p_x,
	output logic signed [tms_pkg::COORD_W-1:0]   p_y,
	output logic signed [tms_pkg::COORD_W-1:0]   p_z,
	output logic signed [tms_pkg::COORD_W-1:0]   q_x,
	output logic signed [tms_pkg::COORD_W-1:0]   q_y,
	output logic signed [tms_pkg::COORD_W-1:0]   q_z,
	output logic signed [tms_pkg::COORD_W-1:0]   r_x,
	output logic signed [tms_pkg::COORD_W-1:0]   r_y,
	output logic signed [tms_pkg::COORD_W-1:0]   r_z,
	output logic                                 final_triangle
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DESC,
		S_EMIT,
		S_NEXT,
		S_READ,
		S_LOAD
	} state_t;

	state_t                           state_q;
	logic [tms_pkg::ADDR_W-1:0]       lvl_q;
	logic [tms_pkg::ADDR_W-1:0]       last_q;
	tms_pkg::child_t                  k_q;
	tms_pkg::child_t                  ci_q [tms_pkg::MAX_DEPTH];
	tms_pkg::tri_t                    par_q;
	tms_pkg::tri_t                    out_tri_q;
	logic                             out_valid_q;
	logic                             out_final_q;

	tms_pkg::tri_t                    in_tri;
	tms_pkg::tri_t                    child_tri;
	tms_pkg::tri_t                    rd_tri;
	tms_pkg::child_t                  child_sel;
	logic [tms_pkg::LEVELS_W-1:0]     depth;
	logic [tms_pkg::ADDR_W-1:0]       in_last;
	logic [tms_pkg::ADDR_W-1:0]       lvl_up;
	logic                             in_acc;
	logic                             out_free;
	logic                             anc_done;
	logic                             ram_we;
	logic                             ram_re;
	logic [tms_pkg::ADDR_W-1:0]       ram_waddr;
	tms_pkg::tri_t                    ram_wdata;

	// input triangle and clamped depth
	assign in_tri = '{a: '{x: a_x, y: a_y, z: a_z},
	                  b: '{x: b_x, y: b_y, z: b_z},
	                  c: '{x: c_x, y: c_y, z: c_z}};

	always_comb begin
		depth = (levels == '0) ? tms_pkg::LEVELS_W'(1) : levels;
		if (depth > tms_pkg::LEVELS_W'(tms_pkg::MAX_DEPTH)) begin
			depth = tms_pkg::LEVELS_W'(tms_pkg::MAX_DEPTH);
		end
		in_last = tms_pkg::ADDR_W'(depth - tms_pkg::LEVELS_W'(1));
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign lvl_up   = lvl_q + tms_pkg::ADDR_W'(1);

	// all ancestors on their last child
	always_comb begin
		anc_done = 1'b1;
		for (int i = 0; i < tms_pkg::MAX_DEPTH; i++) begin
			if (tms_pkg::ADDR_W'(i) < lvl_q && ci_q[i] != tms_pkg::CH_MID) begin
				anc_done = 1'b0;
			end
		end
	end

	// child generator
	assign child_sel = (state_q == S_EMIT) ? k_q : ci_q[lvl_q];

	tms_split u_split (
		.parent (par_q),
		.sel    (child_sel),
		.child  (child_tri)
	);

	// stack ports: push on accept and descend, read on return
	assign ram_we    = in_acc || (state_q == S_DESC);
	assign ram_waddr = (state_q == S_IDLE) ? '0 : lvl_up;
	assign ram_wdata = (state_q == S_IDLE) ? in_tri : child_tri;
	assign ram_re    = (state_q == S_READ);

	tms_stack_ram u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (lvl_q),
		.rdata (rd_tri)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lvl_q       <= '0;
			last_q      <= '0;
			k_q         <= tms_pkg::CH_A;
			out_valid_q <= 1'b0;
			out_final_q <= 1'b0;
			for (int i = 0; i < tms_pkg::MAX_DEPTH; i++) begin
				ci_q[i] <= tms_pkg::CH_A;
			end
		end else begin
			// drains here unless the emit state reloads it
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						par_q  <= in_tri;
						last_q <= in_last;
						lvl_q  <= '0;
						k_q    <= tms_pkg::CH_A;
						for (int i = 0; i < tms_pkg::MAX_DEPTH; i++) begin
							ci_q[i] <= tms_pkg::CH_A;
						end
						state_q <= (in_last == '0) ? S_EMIT : S_DESC;
					end
				end
				S_DESC: begin
					par_q       <= child_tri;
					lvl_q       <= lvl_up;
					ci_q[lvl_up] <= tms_pkg::CH_A;
					if (lvl_up == last_q) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_tri_q   <= child_tri;
						out_final_q <= (k_q == tms_pkg::CH_MID) && anc_done;
						out_valid_q <= 1'b1;
						k_q         <= tms_pkg::child_t'(k_q + 2'd1);
						if (k_q == tms_pkg::CH_MID) begin
							if (lvl_q == '0) begin
								state_q <= S_IDLE;
							end else begin
								lvl_q   <= lvl_q - tms_pkg::ADDR_W'(1);
								state_q <= S_NEXT;
							end
						end
					end
				end
				S_NEXT: begin
					if (ci_q[lvl_q] == tms_pkg::CH_MID) begin
						if (lvl_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							lvl_q <= lvl_q - tms_pkg::ADDR_W'(1);
						end
					end else begin
						ci_q[lvl_q] <= tms_pkg::child_t'(ci_q[lvl_q] + 2'd1);
						state_q     <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					par_q   <= rd_tri;
					state_q <= S_DESC;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result ports
	assign out_valid      = out_valid_q;
	assign final_triangle = out_final_q;
	assign p_x = out_tri_q.a.x;
	assign p_y = out_tri_q.a.y;
	assign p_z = out_tri_q.a.z;
	assign q_x = out_tri_q.b.x;
	assign q_y = out_tri_q.b.y;
	assign q_z = out_tri_q.b.z;
	assign r_x = out_tri_q.c.x;
	assign r_y = out_tri_q.c.y;
	assign r_z = out_tri_q.c.z;

	// checks
	`TMS_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_q != S_IDLE)
	`TMS_ASSERT_IMPL(a_lvl_range, state_q != S_IDLE, lvl_q <= last_q)
	`TMS_ASSERT_IMPL(a_ram_one_port, ram_re, !ram_we)
	`TMS_ASSERT_NEXT(a_emit_loads, state_q == S_EMIT && out_free, out_valid_q)

endmodule
